[sv/rsg_pkg.sv]
// package: types, constants and coefficient tables for the gf64 rs encoder
package rsg_pkg;

  localparam int unsigned SymW    = 6;
  localparam int unsigned MaxPar  = 16;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ParIdxW = 4;
  localparam int unsigned QueueDepth = 4;

  typedef logic [SymW-1:0] sym_t;

  typedef enum logic [1:0] {
    MODE_A = 2'd0,
    MODE_B = 2'd1,
    MODE_C = 2'd2,
    MODE_R = 2'd3
  } mode_e;

  // classified word handed from front to back
  typedef struct packed {
    sym_t         data;
    logic         last;
    logic [ParIdxW-1:0] par_last;
  } job_t;

  typedef logic [MaxPar*SymW-1:0] row_t;

  function automatic sym_t gf_mul(input sym_t x, input sym_t y);
    sym_t acc;
    sym_t a;
    acc = '0;
    a   = x;
    for (int i = 0; i < SymW; i++) begin
      if (y[i]) acc = acc ^ a;
      a = a[SymW-1] ? ({a[SymW-2:0], 1'b0} ^ sym_t'(6'h03)) : {a[SymW-2:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [4:0] data_len(input mode_e m);
    unique case (m)
      MODE_B:  return 5'd16;
      MODE_C:  return 5'd20;
      default: return 5'd12;
    endcase
  endfunction

  function automatic logic [ParIdxW-1:0] par_last(input mode_e m);
    unique case (m)
      MODE_B:  return 4'd7;
      MODE_C:  return 4'd15;
      default: return 4'd11;
    endcase
  endfunction

  function automatic row_t pack_row(input logic [7:0] r [16]);
    row_t v;
    for (int i = 0; i < MaxPar; i++) v[i*SymW +: SymW] = r[i][SymW-1:0];
    return v;
  endfunction

  // one row of coefficients for a mode and position, unused columns zero
  function automatic row_t coef_row(input mode_e m, input logic [PosW-1:0] pos);
    logic [7:0] r [16];
    for (int i = 0; i < 16; i++) r[i] = 8'd0;
    if (m == MODE_B) begin
      case (pos[3:0])
        4'd0:  r[0:7] = '{8'o51,8'o45,8'o67,8'o15,8'o64,8'o67,8'o52,8'o12};
        4'd1:  r[0:7] = '{8'o57,8'o25,8'o63,8'o73,8'o71,8'o22,8'o40,8'o15};
        4'd2:  r[0:7] = '{8'o05,8'o01,8'o31,8'o04,8'o16,8'o54,8'o25,8'o76};
        4'd3:  r[0:7] = '{8'o73,8'o07,8'o47,8'o14,8'o41,8'o77,8'o47,8'o11};
        4'd4:  r[0:7] = '{8'o75,8'o15,8'o51,8'o51,8'o17,8'o67,8'o17,8'o57};
        4'd5:  r[0:7] = '{8'o20,8'o32,8'o14,8'o42,8'o75,8'o42,8'o70,8'o54};
        4'd6:  r[0:7] = '{8'o02,8'o75,8'o43,8'o05,8'o01,8'o40,8'o12,8'o64};
        4'd7:  r[0:7] = '{8'o24,8'o74,8'o15,8'o72,8'o24,8'o26,8'o74,8'o61};
        4'd8:  r[0:7] = '{8'o42,8'o64,8'o07,8'o22,8'o61,8'o20,8'o40,8'o65};
        4'd9:  r[0:7] = '{8'o32,8'o32,8'o55,8'o41,8'o57,8'o66,8'o21,8'o77};
        4'd10: r[0:7] = '{8'o65,8'o36,8'o25,8'o07,8'o50,8'o16,8'o40,8'o51};
        4'd11: r[0:7] = '{8'o64,8'o06,8'o54,8'o32,8'o76,8'o46,8'o14,8'o36};
        4'd12: r[0:7] = '{8'o62,8'o63,8'o74,8'o70,8'o05,8'o27,8'o37,8'o46};
        4'd13: r[0:7] = '{8'o55,8'o43,8'o34,8'o71,8'o57,8'o76,8'o50,8'o64};
        4'd14: r[0:7] = '{8'o24,8'o23,8'o23,8'o05,8'o50,8'o70,8'o42,8'o23};
        default: r[0:7] = '{8'o67,8'o75,8'o45,8'o60,8'o57,8'o24,8'o06,8'o26};
      endcase
    end else if (m == MODE_C) begin
      case (pos)
        5'd0:  r = '{8'o74,8'o37,8'o34,8'o06,8'o02,8'o07,8'o44,8'o64,
                     8'o26,8'o14,8'o26,8'o44,8'o54,8'o13,8'o77,8'o05};
        5'd1:  r = '{8'o04,8'o17,8'o50,8'o24,8'o11,8'o05,8'o30,8'o57,
                     8'o33,8'o03,8'o02,8'o02,8'o15,8'o16,8'o25,8'o26};
        5'd2:  r = '{8'o07,8'o23,8'o37,8'o46,8'o56,8'o75,8'o43,8'o45,
                     8'o55,8'o21,8'o50,8'o31,8'o45,8'o27,8'o71,8'o62};
        5'd3:  r = '{8'o26,8'o05,8'o07,8'o63,8'o63,8'o27,8'o63,8'o40,
                     8'o06,8'o04,8'o40,8'o45,8'o47,8'o30,8'o75,8'o07};
        5'd4:  r = '{8'o23,8'o73,8'o73,8'o41,8'o72,8'o34,8'o21,8'o51,
                     8'o67,8'o16,8'o31,8'o74,8'o11,8'o21,8'o12,8'o21};
        5'd5:  r = '{8'o24,8'o51,8'o25,8'o23,8'o22,8'o41,8'o74,8'o66,
                     8'o74,8'o65,8'o70,8'o36,8'o67,8'o45,8'o64,8'o01};
        5'd6:  r = '{8'o52,8'o33,8'o14,8'o02,8'o20,8'o06,8'o14,8'o25,
                     8'o52,8'o23,8'o35,8'o74,8'o75,8'o75,8'o43,8'o27};
        5'd7:  r = '{8'o55,8'o62,8'o56,8'o25,8'o73,8'o60,8'o15,8'o30,
                     8'o13,8'o17,8'o20,8'o02,8'o70,8'o55,8'o14,8'o47};
        5'd8:  r = '{8'o54,8'o51,8'o32,8'o65,8'o77,8'o12,8'o54,8'o13,
                     8'o35,8'o32,8'o56,8'o12,8'o75,8'o01,8'o72,8'o63};
        5'd9:  r = '{8'o74,8'o41,8'o30,8'o41,8'o43,8'o22,8'o51,8'o06,
                     8'o64,8'o33,8'o03,8'o47,8'o27,8'o12,8'o55,8'o47};
        5'd10: r = '{8'o54,8'o70,8'o11,8'o03,8'o13,8'o22,8'o16,8'o57,
                     8'o03,8'o45,8'o72,8'o31,8'o30,8'o56,8'o35,8'o22};
        5'd11: r = '{8'o51,8'o07,8'o72,8'o30,8'o65,8'o54,8'o06,8'o21,
                     8'o36,8'o63,8'o50,8'o61,8'o64,8'o52,8'o01,8'o60};
        5'd12: r = '{8'o01,8'o65,8'o32,8'o70,8'o13,8'o44,8'o73,8'o24,
                     8'o12,8'o52,8'o21,8'o55,8'o12,8'o35,8'o14,8'o72};
        5'd13: r = '{8'o11,8'o70,8'o05,8'o10,8'o65,8'o24,8'o15,8'o77,
                     8'o22,8'o24,8'o24,8'o74,8'o07,8'o44,8'o07,8'o46};
        5'd14: r = '{8'o06,8'o02,8'o65,8'o11,8'o41,8'o20,8'o45,8'o42,
                     8'o46,8'o54,8'o35,8'o12,8'o40,8'o64,8'o65,8'o33};
        5'd15: r = '{8'o34,8'o31,8'o01,8'o15,8'o44,8'o64,8'o16,8'o24,
                     8'o52,8'o16,8'o06,8'o62,8'o20,8'o13,8'o55,8'o57};
        5'd16: r = '{8'o63,8'o43,8'o25,8'o44,8'o77,8'o63,8'o17,8'o17,
                     8'o64,8'o14,8'o40,8'o74,8'o31,8'o72,8'o54,8'o06};
        5'd17: r = '{8'o71,8'o21,8'o70,8'o44,8'o56,8'o04,8'o30,8'o74,
                     8'o04,8'o23,8'o71,8'o70,8'o63,8'o45,8'o56,8'o43};
        5'd18: r = '{8'o02,8'o01,8'o53,8'o74,8'o02,8'o14,8'o52,8'o74,
                     8'o12,8'o57,8'o24,8'o63,8'o15,8'o42,8'o52,8'o33};
        5'd19: r = '{8'o34,8'o35,8'o02,8'o23,8'o21,8'o27,8'o22,8'o33,
                     8'o64,8'o42,8'o05,8'o73,8'o51,8'o46,8'o73,8'o60};
        default: ;
      endcase
    end else begin
      case (pos)
        5'd0:  r[0:11] = '{8'o62,8'o44,8'o03,8'o25,8'o14,8'o16,8'o27,8'o03,8'o53,8'o04,8'o36,8'o47};
        5'd1:  r[0:11] = '{8'o11,8'o12,8'o11,8'o11,8'o16,8'o64,8'o67,8'o55,8'o01,8'o76,8'o26,8'o73};
        5'd2:  r[0:11] = '{8'o03,8'o01,8'o05,8'o75,8'o14,8'o06,8'o20,8'o44,8'o66,8'o06,8'o70,8'o66};
        5'd3:  r[0:11] = '{8'o21,8'o70,8'o27,8'o45,8'o16,8'o67,8'o23,8'o64,8'o73,8'o33,8'o44,8'o21};
        5'd4:  r[0:11] = '{8'o30,8'o22,8'o03,8'o75,8'o15,8'o15,8'o33,8'o15,8'o51,8'o03,8'o53,8'o50};
        5'd5:  r[0:11] = '{8'o01,8'o41,8'o27,8'o56,8'o76,8'o64,8'o21,8'o53,8'o04,8'o25,8'o01,8'o12};
        5'd6:  r[0:11] = '{8'o61,8'o76,8'o21,8'o55,8'o76,8'o01,8'o63,8'o35,8'o30,8'o13,8'o64,8'o70};
        5'd7:  r[0:11] = '{8'o24,8'o22,8'o71,8'o56,8'o21,8'o35,8'o73,8'o42,8'o57,8'o74,8'o43,8'o76};
        5'd8:  r[0:11] = '{8'o72,8'o42,8'o05,8'o20,8'o43,8'o47,8'o33,8'o56,8'o01,8'o16,8'o13,8'o76};
        5'd9:  r[0:11] = '{8'o72,8'o14,8'o65,8'o54,8'o35,8'o25,8'o41,8'o16,8'o15,8'o40,8'o71,8'o26};
        5'd10: r[0:11] = '{8'o73,8'o65,8'o36,8'o61,8'o42,8'o22,8'o17,8'o04,8'o44,8'o20,8'o25,8'o05};
        5'd11: r[0:11] = '{8'o71,8'o05,8'o55,8'o03,8'o71,8'o34,8'o60,8'o11,8'o74,8'o02,8'o41,8'o50};
        default: ;
      endcase
    end
    return pack_row(r);
  endfunction

endpackage

[sv/rsg_front.sv]
// front end: tracks word position, multiplies into parity accumulators, registers words for the back end
module rsg_front import rsg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_valid_i,
  input  logic [1:0] cfg_data_i,
  input  logic   in_valid_i,
  input  sym_t   in_data_i,
  output logic   job_valid_o,
  output job_t   job_o,
  output row_t   par_o
);

  mode_e             mode_q;
  logic [PosW-1:0]   pos_q, pos_d, pos_eff;
  row_t              acc_q, acc_d, coefs;
  logic [4:0]        klen;
  logic              first, last, fire;

  assign klen    = data_len(mode_q);
  assign pos_eff = (pos_q >= klen) ? '0 : pos_q;
  assign first   = (pos_eff == '0);
  assign last    = (pos_eff + 5'd1 == klen);
  assign coefs   = coef_row(mode_q, pos_eff);
  assign fire    = in_valid_i;

  always_comb begin
    for (int c = 0; c < MaxPar; c++) begin
      acc_d[c*SymW +: SymW] = gf_mul(in_data_i, coefs[c*SymW +: SymW])
                            ^ (first ? sym_t'(0) : acc_q[c*SymW +: SymW]);
    end
    pos_d = last ? '0 : pos_eff + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_A;
      pos_q       <= '0;
      job_valid_o <= 1'b0;
    end else begin
      job_valid_o <= fire;
      if (cfg_valid_i) begin
        mode_q <= mode_e'(cfg_data_i);
        pos_q  <= '0;
      end else if (fire) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q         <= acc_d;
      par_o         <= acc_d;
      job_o.data    <= in_data_i;
      job_o.last    <= last;
      job_o.par_last <= par_last(mode_q);
    end
  end

endmodule

[sv/rsg_back.sv]
// back end: word queue and output sequencer for data and parity symbols
module rsg_back import rsg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   job_valid_i,
  input  job_t   job_i,
  input  row_t   par_i,
  output logic   almost_full_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output sym_t   out_data_o,
  output logic   out_parity_o,
  output logic   out_last_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t  q_job [Depth];
  row_t  q_par [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          in_par_q;
  logic [ParIdxW-1:0] idx_q;
  job_t  head;
  row_t  hpar;
  logic  pop, take;

  assign head = q_job[rd_q];
  assign hpar = q_par[rd_q];
  assign out_valid_o  = (cnt_q != '0);
  assign out_parity_o = in_par_q;
  assign out_data_o   = in_par_q ? hpar[idx_q*SymW +: SymW] : head.data;
  assign out_last_o   = in_par_q && (idx_q == head.par_last);
  assign take = out_valid_o && out_ready_i;
  assign pop  = take && (in_par_q ? out_last_o : !head.last);
  // front issues blindly, so stop input two words ahead
  assign almost_full_o = (cnt_q >= (AW+1)'(Depth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; in_par_q <= 1'b0; idx_q <= '0;
    end else begin
      if (job_valid_i) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(job_valid_i) - (AW+1)'(pop);
      if (take) begin
        if (!in_par_q && head.last) begin
          in_par_q <= 1'b1; idx_q <= '0;
        end else if (in_par_q) begin
          if (out_last_o) in_par_q <= 1'b0;
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) begin
      q_job[wr_q] <= job_i;
      q_par[wr_q] <= par_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (AW+1)'(Depth) |-> !job_valid_i) else $error("push into full queue");
  a_parity_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_par_q |-> idx_q <= head.par_last) else $error("parity index past end");
`endif

endmodule

[sv/rs_gf64_systematic_encoder_core.sv]
// top level of the gf64 reed-solomon systematic encoder
// Takes one 6-bit data symbol per cycle and echoes it, then after the last data
// symbol of a word emits 12, 8 or 16 parity symbols (one per cycle while
// m_axis_tready is high) with the final one flagged. The parity of each symbol
// is computed in the cycle it is accepted by 16 gf(64) multipliers fed from the
// coefficient table; a 4-entry word queue feeds the output sequencer, so input
// flows at one symbol per cycle except during a parity burst or output stall,
// where input stops once two entries wait in the queue and resumes as they drain.
module rs_gf64_systematic_encoder_core import rsg_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,     // [1:0] code_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [5:0] data_symbol
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [5:0] code_symbol
  output logic       m_axis_tlast,   // word_end
  output logic       m_axis_tuser    // is_parity
);

  logic job_valid, afull, in_ok;
  job_t job;
  row_t par;
  sym_t osym;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !afull;
  assign in_ok         = s_axis_tvalid && !afull;
  assign m_axis_tdata  = {2'b00, osym};

  rsg_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i[1:0]),
    .in_valid_i  (in_ok),
    .in_data_i   (s_axis_tdata[5:0]),
    .job_valid_o (job_valid),
    .job_o       (job),
    .par_o       (par)
  );

  rsg_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i  (job_valid),
    .job_i        (job),
    .par_i        (par),
    .almost_full_o(afull),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (osym),
    .out_parity_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

[tb/rs_gf64_systematic_encoder_core_tb.sv]
// testbench for the gf64 reed-solomon systematic encoder core
`timescale 1ns / 1ps
module rs_gf64_systematic_encoder_core_tb;
  import rsg_pkg::*;

  typedef struct {
    sym_t code;
    logic par;
    logic wend;
  } code_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  code_word_t expected_q[$];
  int         mismatches = 0;
  bit         idle_on = 1'b1;
  logic [1:0] mode_reg = '0;
  int         sym_pos = 0;
  sym_t       parity_acc[16];

  rs_gf64_systematic_encoder_core dut (.*);

  always #5 clk_i = ~clk_i;

  // coefficient tables, octal as in the code definitions
  localparam logic [5:0] TAB_A [12][12] = '{
    '{6'o62,6'o44,6'o03,6'o25,6'o14,6'o16,6'o27,6'o03,6'o53,6'o04,6'o36,6'o47},
    '{6'o11,6'o12,6'o11,6'o11,6'o16,6'o64,6'o67,6'o55,6'o01,6'o76,6'o26,6'o73},
    '{6'o03,6'o01,6'o05,6'o75,6'o14,6'o06,6'o20,6'o44,6'o66,6'o06,6'o70,6'o66},
    '{6'o21,6'o70,6'o27,6'o45,6'o16,6'o67,6'o23,6'o64,6'o73,6'o33,6'o44,6'o21},
    '{6'o30,6'o22,6'o03,6'o75,6'o15,6'o15,6'o33,6'o15,6'o51,6'o03,6'o53,6'o50},
    '{6'o01,6'o41,6'o27,6'o56,6'o76,6'o64,6'o21,6'o53,6'o04,6'o25,6'o01,6'o12},
    '{6'o61,6'o76,6'o21,6'o55,6'o76,6'o01,6'o63,6'o35,6'o30,6'o13,6'o64,6'o70},
    '{6'o24,6'o22,6'o71,6'o56,6'o21,6'o35,6'o73,6'o42,6'o57,6'o74,6'o43,6'o76},
    '{6'o72,6'o42,6'o05,6'o20,6'o43,6'o47,6'o33,6'o56,6'o01,6'o16,6'o13,6'o76},
    '{6'o72,6'o14,6'o65,6'o54,6'o35,6'o25,6'o41,6'o16,6'o15,6'o40,6'o71,6'o26},
    '{6'o73,6'o65,6'o36,6'o61,6'o42,6'o22,6'o17,6'o04,6'o44,6'o20,6'o25,6'o05},
    '{6'o71,6'o05,6'o55,6'o03,6'o71,6'o34,6'o60,6'o11,6'o74,6'o02,6'o41,6'o50}};
  localparam logic [5:0] TAB_B [16][8] = '{
    '{6'o51,6'o45,6'o67,6'o15,6'o64,6'o67,6'o52,6'o12},
    '{6'o57,6'o25,6'o63,6'o73,6'o71,6'o22,6'o40,6'o15},
    '{6'o05,6'o01,6'o31,6'o04,6'o16,6'o54,6'o25,6'o76},
    '{6'o73,6'o07,6'o47,6'o14,6'o41,6'o77,6'o47,6'o11},
    '{6'o75,6'o15,6'o51,6'o51,6'o17,6'o67,6'o17,6'o57},
    '{6'o20,6'o32,6'o14,6'o42,6'o75,6'o42,6'o70,6'o54},
    '{6'o02,6'o75,6'o43,6'o05,6'o01,6'o40,6'o12,6'o64},
    '{6'o24,6'o74,6'o15,6'o72,6'o24,6'o26,6'o74,6'o61},
    '{6'o42,6'o64,6'o07,6'o22,6'o61,6'o20,6'o40,6'o65},
    '{6'o32,6'o32,6'o55,6'o41,6'o57,6'o66,6'o21,6'o77},
    '{6'o65,6'o36,6'o25,6'o07,6'o50,6'o16,6'o40,6'o51},
    '{6'o64,6'o06,6'o54,6'o32,6'o76,6'o46,6'o14,6'o36},
    '{6'o62,6'o63,6'o74,6'o70,6'o05,6'o27,6'o37,6'o46},
    '{6'o55,6'o43,6'o34,6'o71,6'o57,6'o76,6'o50,6'o64},
    '{6'o24,6'o23,6'o23,6'o05,6'o50,6'o70,6'o42,6'o23},
    '{6'o67,6'o75,6'o45,6'o60,6'o57,6'o24,6'o06,6'o26}};
  localparam logic [5:0] TAB_C [20][16] = '{
    '{6'o74,6'o37,6'o34,6'o06,6'o02,6'o07,6'o44,6'o64,
      6'o26,6'o14,6'o26,6'o44,6'o54,6'o13,6'o77,6'o05},
    '{6'o04,6'o17,6'o50,6'o24,6'o11,6'o05,6'o30,6'o57,
      6'o33,6'o03,6'o02,6'o02,6'o15,6'o16,6'o25,6'o26},
    '{6'o07,6'o23,6'o37,6'o46,6'o56,6'o75,6'o43,6'o45,
      6'o55,6'o21,6'o50,6'o31,6'o45,6'o27,6'o71,6'o62},
    '{6'o26,6'o05,6'o07,6'o63,6'o63,6'o27,6'o63,6'o40,
      6'o06,6'o04,6'o40,6'o45,6'o47,6'o30,6'o75,6'o07},
    '{6'o23,6'o73,6'o73,6'o41,6'o72,6'o34,6'o21,6'o51,
      6'o67,6'o16,6'o31,6'o74,6'o11,6'o21,6'o12,6'o21},
    '{6'o24,6'o51,6'o25,6'o23,6'o22,6'o41,6'o74,6'o66,
      6'o74,6'o65,6'o70,6'o36,6'o67,6'o45,6'o64,6'o01},
    '{6'o52,6'o33,6'o14,6'o02,6'o20,6'o06,6'o14,6'o25,
      6'o52,6'o23,6'o35,6'o74,6'o75,6'o75,6'o43,6'o27},
    '{6'o55,6'o62,6'o56,6'o25,6'o73,6'o60,6'o15,6'o30,
      6'o13,6'o17,6'o20,6'o02,6'o70,6'o55,6'o14,6'o47},
    '{6'o54,6'o51,6'o32,6'o65,6'o77,6'o12,6'o54,6'o13,
      6'o35,6'o32,6'o56,6'o12,6'o75,6'o01,6'o72,6'o63},
    '{6'o74,6'o41,6'o30,6'o41,6'o43,6'o22,6'o51,6'o06,
      6'o64,6'o33,6'o03,6'o47,6'o27,6'o12,6'o55,6'o47},
    '{6'o54,6'o70,6'o11,6'o03,6'o13,6'o22,6'o16,6'o57,
      6'o03,6'o45,6'o72,6'o31,6'o30,6'o56,6'o35,6'o22},
    '{6'o51,6'o07,6'o72,6'o30,6'o65,6'o54,6'o06,6'o21,
      6'o36,6'o63,6'o50,6'o61,6'o64,6'o52,6'o01,6'o60},
    '{6'o01,6'o65,6'o32,6'o70,6'o13,6'o44,6'o73,6'o24,
      6'o12,6'o52,6'o21,6'o55,6'o12,6'o35,6'o14,6'o72},
    '{6'o11,6'o70,6'o05,6'o10,6'o65,6'o24,6'o15,6'o77,
      6'o22,6'o24,6'o24,6'o74,6'o07,6'o44,6'o07,6'o46},
    '{6'o06,6'o02,6'o65,6'o11,6'o41,6'o20,6'o45,6'o42,
      6'o46,6'o54,6'o35,6'o12,6'o40,6'o64,6'o65,6'o33},
    '{6'o34,6'o31,6'o01,6'o15,6'o44,6'o64,6'o16,6'o24,
      6'o52,6'o16,6'o06,6'o62,6'o20,6'o13,6'o55,6'o57},
    '{6'o63,6'o43,6'o25,6'o44,6'o77,6'o63,6'o17,6'o17,
      6'o64,6'o14,6'o40,6'o74,6'o31,6'o72,6'o54,6'o06},
    '{6'o71,6'o21,6'o70,6'o44,6'o56,6'o04,6'o30,6'o74,
      6'o04,6'o23,6'o71,6'o70,6'o63,6'o45,6'o56,6'o43},
    '{6'o02,6'o01,6'o53,6'o74,6'o02,6'o14,6'o52,6'o74,
      6'o12,6'o57,6'o24,6'o63,6'o15,6'o42,6'o52,6'o33},
    '{6'o34,6'o35,6'o02,6'o23,6'o21,6'o27,6'o22,6'o33,
      6'o64,6'o42,6'o05,6'o73,6'o51,6'o46,6'o73,6'o60}};

  function automatic sym_t field_mult(sym_t x, sym_t y);
    logic [6:0] a;
    sym_t       acc;
    acc = '0;
    a = {1'b0, x};
    for (int i = 0; i < 6; i++) begin
      if (y[i]) acc ^= a[5:0];
      a = a << 1;
      if (a[6]) a ^= 7'h43;
    end
    return acc;
  endfunction

  // update parity for one data symbol and queue the code symbols it yields
  task automatic encode_symbol(sym_t d);
    int   k, p;
    sym_t c;
    case (mode_e'(mode_reg))
      MODE_B: begin k = 16; p = 8; end
      MODE_C: begin k = 20; p = 16; end
      default: begin k = 12; p = 12; end
    endcase
    if (sym_pos >= k) sym_pos = 0;
    for (int i = 0; i < p; i++) begin
      case (mode_e'(mode_reg))
        MODE_B:  c = TAB_B[sym_pos][i];
        MODE_C:  c = TAB_C[sym_pos][i];
        default: c = TAB_A[sym_pos][i];
      endcase
      parity_acc[i] = (sym_pos == 0) ? field_mult(d, c) : parity_acc[i] ^ field_mult(d, c);
    end
    expected_q.push_back('{d, 1'b0, 1'b0});
    if (sym_pos + 1 == k) begin
      for (int i = 0; i < p; i++) expected_q.push_back('{parity_acc[i], 1'b1, i == p - 1});
      sym_pos = 0;
    end else begin
      sym_pos++;
    end
  endtask

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic send_symbol(sym_t d);
    idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_symbol(d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= {6'b0, m};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_reg = m;
    sym_pos = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always begin
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    code_word_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata !== {2'b00, e.code} || m_axis_tuser !== e.par ||
            m_axis_tlast !== e.wend) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sym %h par %b end %b, got %h %b %b",
                     e.code, e.par, e.wend, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  task automatic test_directed();
    logic [1:0] m;
    // extremes and a full word in each mode, reserved mode too
    for (int mi = 0; mi < 4; mi++) begin
      m = 2'(mi);
      write_mode(m);
      send_symbol(6'h00);
      send_symbol(6'h3f);
      for (int i = 0; i < 18; i++) send_symbol(6'h01 << (i % 6));
    end
    // mode write mid-word aborts it
    write_mode(MODE_C);
    repeat (5) send_symbol(6'h2a);
    write_mode(MODE_A);
    repeat (12) send_symbol(6'h15);
  endtask

  task automatic test_random();
    logic [1:0] m;
    for (int w = 0; w < 12; w++) begin
      if ($urandom_range(0, 2) == 0) begin
        m = 2'($urandom_range(0, 3));
        write_mode(m);
      end
      if (w == 6) drain();
      repeat ($urandom_range(12, 22)) send_symbol(sym_t'($urandom_range(0, 63)));
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    write_mode(MODE_C);
    repeat (40) send_symbol(sym_t'($urandom_range(0, 63)));
    write_mode(MODE_B);
    repeat (32) send_symbol(sym_t'($urandom_range(0, 63)));
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_full_rate();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

[files.f]
sv/rsg_pkg.sv
sv/rsg_front.sv
sv/rsg_back.sv
sv/rs_gf64_systematic_encoder_core.sv
tb/rs_gf64_systematic_encoder_core_tb.sv
